// ----- design/ctsp_pkg.sv -----
// Shared types and constants of the camera target sentence parser.
package ctsp_pkg;

    localparam int SENTENCE_LEN = 9;     // required sentence length in bytes (3..64)
    localparam int LEN_W        = 7;     // saturating length counter width
    localparam int COORD_W      = 16;
    localparam int CHAR_W       = 8;
    localparam int APB_AW       = 3;
    localparam int APB_DW       = 32;

    typedef logic [CHAR_W-1:0]         t_char;
    typedef logic signed [COORD_W-1:0] t_coord;

    typedef enum logic [1:0] {
        ST_WRONG_LEN = 2'd0,
        ST_MALFORMED = 2'd1,
        ST_NO_TARGET = 2'd2,
        ST_TARGET    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CABLE_UP       = 2'd0,
        CABLE_DOWN     = 2'd1,
        CABLE_TO_RIGHT = 2'd2,
        CABLE_TO_LEFT  = 2'd3
    } t_cable;

    // Register indexes on the configuration port
    localparam logic REG_CABLE_DIR = 1'b0;

    localparam t_char CH_START = 8'h53;  // 'S'
    localparam t_char CH_FINAL = 8'h46;  // 'F'
    localparam t_char CH_COMMA = 8'h2C;  // ','
    localparam t_char CH_PLUS  = 8'h2B;  // '+'
    localparam t_char CH_MINUS = 8'h2D;  // '-'
    localparam t_char CH_ZERO  = 8'h30;  // '0'
    localparam t_char CH_NINE  = 8'h39;  // '9'
    localparam t_char CH_SPACE = 8'h20;
    localparam t_char CH_TAB   = 8'h09;
    localparam t_char CH_CR    = 8'h0D;

    localparam t_coord NO_TARGET_VAL = 16'sd999;

endpackage

// ----- design/ctsp_char_if.sv -----
// Input channel: one received character per transaction.
interface ctsp_char_if;
    import ctsp_pkg::*;

    logic  valid;
    logic  ready;
    t_char char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

// ----- design/ctsp_result_if.sv -----
// Output channel: one sentence status per transaction.
interface ctsp_result_if;
    import ctsp_pkg::*;

    logic    valid;
    logic    ready;
    t_status status;
    t_coord  frame_x;
    t_coord  frame_y;
    logic    target_in_view;

    modport source (output valid, output status, output frame_x, output frame_y,
                    output target_in_view, input ready);
    modport sink   (input valid, input status, input frame_x, input frame_y,
                    input target_in_view, output ready);
endinterface

// ----- design/camera_target_sentence_parser.sv -----
// Top level of the camera target sentence parser.
//
//  channel      dir  handshake        payload
//  i_char_ch    in   valid/ready      char_in[7:0]
//  o_result_ch  out  valid/ready      status[1:0], frame_x[15:0], frame_y[15:0],
//                                     target_in_view
//  APB          in   psel/penable     paddr[2:0], pwdata/prdata[31:0] (cable_direction)
//
// Flow: one character per clock unless an 'F' is blocked; a character is registered on
//   acceptance and parsed in the next cycle, then an 'F' result goes to the result register.
// The parse step (one multiply-by-ten and add on a 17-bit magnitude, then the
//   rotation select) is the combinational logic of the parse stage.
// Reset: synchronous, active low; clears parser state, held position and
//   sets cable_direction to cable down. No clearing pass.
// Stalls: only an 'F' waits on a full result register; other characters
//   never stall, so input ready drops only while an 'F' is blocked.
module camera_target_sentence_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ctsp_char_if.sink                     i_char_ch,
    ctsp_result_if.source                 o_result_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ctsp_pkg::APB_AW-1:0]   paddr,
    input  logic [ctsp_pkg::APB_DW-1:0]   pwdata,
    output logic [ctsp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import ctsp_pkg::*;

    localparam logic [LEN_W-1:0] LenTarget = LEN_W'(SENTENCE_LEN);
    localparam logic [LEN_W-1:0] LenMax    = {LEN_W{1'b1}};
    localparam logic [COORD_W:0] MagMax    = (COORD_W+1)'(1) << (COORD_W-1); // 32768

    // Field phases
    typedef enum logic [1:0] {
        PH_BLANKS = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_STOP   = 2'd3
    } t_phase;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    // Signed field value from sign and saturated magnitude (0..32768)
    function automatic t_coord field_val(input logic neg, input logic [COORD_W:0] mag);
        t_coord m16;
        m16 = t_coord'(mag[COORD_W-1:0]);
        if (neg) begin
            return -m16;                       // 32768 wraps to -32768 exactly
        end else if (mag[COORD_W-1]) begin
            return {1'b0, {(COORD_W-1){1'b1}}};  // clamp to 32767
        end
        return m16;
    endfunction

    function automatic t_coord neg_sat(input t_coord v);
        if (v == {1'b1, {(COORD_W-1){1'b0}}}) begin
            return {1'b0, {(COORD_W-1){1'b1}}};
        end
        return -v;
    endfunction

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    t_cable r_cable;
    logic   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_CABLE_DIR);

    always_comb begin
        prdata = '0;
        if (paddr[APB_AW-1] == REG_CABLE_DIR) begin
            prdata = APB_DW'(r_cable);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cable <= CABLE_DOWN;
        end else if (cfg_wr) begin
            r_cable <= t_cable'(pwdata[1:0]);
        end
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic  r_in_valid;
    t_char r_in_char;
    logic  out_free;
    logic  fire;
    logic  is_final;

    assign is_final = (r_in_char == CH_FINAL);
    assign out_free = !o_result_ch.valid || o_result_ch.ready;
    // An 'F' needs room in the result register; anything else always proceeds
    assign fire     = r_in_valid && (!is_final || out_free);
    assign i_char_ch.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char_ch.ready) begin
            r_in_valid <= i_char_ch.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char_ch.valid && i_char_ch.ready) begin
            r_in_char <= i_char_ch.char_in;
        end
    end

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [LEN_W-1:0]   r_len,       n_len;
    logic [1:0]         r_fnum,      n_fnum;      // 0 first, 1 second, 2 done
    t_phase             r_phase,     n_phase;
    logic               r_neg,       n_neg;
    logic               r_has_dig,   n_has_dig;
    logic [COORD_W:0]   r_mag,       n_mag;       // 0..32768
    t_coord             r_first,     n_first;
    logic               r_first_ok,  n_first_ok;
    t_coord             r_held_x,    n_held_x;
    t_coord             r_held_y,    n_held_y;
    logic               r_seen,      n_seen;
    logic               r_out_valid, n_out_valid;
    t_status            r_status,    n_status;

    logic               is_digit, is_blank, is_sign;
    logic [3:0]         dig;
    logic [COORD_W+3:0] acc;
    t_coord             cx, cy;

    assign is_digit = (r_in_char >= CH_ZERO) && (r_in_char <= CH_NINE);
    assign is_blank = (r_in_char == CH_SPACE) ||
                      ((r_in_char >= CH_TAB) && (r_in_char <= CH_CR));
    assign is_sign  = (r_in_char == CH_PLUS) || (r_in_char == CH_MINUS);
    assign dig      = 4'(r_in_char - CH_ZERO);
    // mag*10 + digit
    assign acc      = {r_mag, 3'b000} + (COORD_W+4)'({r_mag, 1'b0}) + (COORD_W+4)'(dig);
    assign cx       = r_first;
    assign cy       = field_val(r_neg, r_mag);

    always_comb begin
        n_len       = r_len;
        n_fnum      = r_fnum;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_has_dig   = r_has_dig;
        n_mag       = r_mag;
        n_first     = r_first;
        n_first_ok  = r_first_ok;
        n_held_x    = r_held_x;
        n_held_y    = r_held_y;
        n_seen      = r_seen;
        n_status    = r_status;
        n_out_valid = r_out_valid && !o_result_ch.ready;

        if (fire) begin
            if (r_in_char == CH_START) begin
                n_len      = '0;
                n_fnum     = '0;
                n_first    = '0;
                n_first_ok = 1'b0;
                n_phase    = PH_BLANKS;
                n_neg      = 1'b0;
                n_has_dig  = 1'b0;
                n_mag      = '0;
            end else if (is_final) begin
                n_out_valid = 1'b1;
                if (r_len != LenTarget) begin
                    n_status = ST_WRONG_LEN;
                end else if (!r_first_ok || (r_fnum == 2'd0) || !r_has_dig) begin
                    n_status = ST_MALFORMED;
                end else if ((cx == NO_TARGET_VAL) && (cy == NO_TARGET_VAL)) begin
                    n_status = ST_NO_TARGET;
                    n_seen   = 1'b0;
                end else begin
                    n_status = ST_TARGET;
                    n_seen   = 1'b1;
                    case (r_cable)
                        CABLE_UP: begin
                            n_held_x = neg_sat(cx);
                            n_held_y = neg_sat(cy);
                        end
                        CABLE_TO_RIGHT: begin
                            n_held_x = neg_sat(cy);
                            n_held_y = cx;
                        end
                        CABLE_TO_LEFT: begin
                            n_held_x = cy;
                            n_held_y = neg_sat(cx);
                        end
                        default: begin
                            n_held_x = cx;
                            n_held_y = cy;
                        end
                    endcase
                end
            end else begin
                if (r_len != LenMax) begin
                    n_len = r_len + 1'b1;
                end
                if (r_fnum < 2'd2) begin
                    if (r_in_char == CH_COMMA) begin
                        if (r_fnum == 2'd0) begin
                            n_first    = cy;
                            n_first_ok = r_has_dig;
                            n_phase    = PH_BLANKS;
                            n_neg      = 1'b0;
                            n_has_dig  = 1'b0;
                            n_mag      = '0;
                        end
                        n_fnum = r_fnum + 1'b1;
                    end else if (r_phase == PH_BLANKS && is_blank) begin
                        n_phase = PH_BLANKS;
                    end else if (r_phase == PH_BLANKS && is_sign) begin
                        n_neg   = (r_in_char == CH_MINUS);
                        n_phase = PH_SIGN;
                    end else if (r_phase != PH_STOP) begin
                        if (is_digit) begin
                            n_mag     = (acc > (COORD_W+4)'(MagMax)) ? MagMax
                                                                    : acc[COORD_W:0];
                            n_has_dig = 1'b1;
                            n_phase   = PH_DIGITS;
                        end else begin
                            n_phase = PH_STOP;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_fnum      <= '0;
            r_phase     <= PH_BLANKS;
            r_neg       <= 1'b0;
            r_has_dig   <= 1'b0;
            r_mag       <= '0;
            r_first     <= '0;
            r_first_ok  <= 1'b0;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
            r_status    <= ST_WRONG_LEN;
        end else begin
            r_len       <= n_len;
            r_fnum      <= n_fnum;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_has_dig   <= n_has_dig;
            r_mag       <= n_mag;
            r_first     <= n_first;
            r_first_ok  <= n_first_ok;
            r_held_x    <= n_held_x;
            r_held_y    <= n_held_y;
            r_seen      <= n_seen;
            r_out_valid <= n_out_valid;
            r_status    <= n_status;
        end
    end

    // Held position only changes when an 'F' is parsed, which needs a free
    // result slot, so it is stable while a result waits.
    assign o_result_ch.valid          = r_out_valid;
    assign o_result_ch.status         = r_status;
    assign o_result_ch.frame_x        = r_held_x;
    assign o_result_ch.frame_y        = r_held_y;
    assign o_result_ch.target_in_view = r_seen;

`ifndef ASSERT_OFF
    a_target_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_TARGET) |-> r_seen)
        else $error("target found but target_in_view low");

    a_no_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_status == ST_NO_TARGET) |-> !r_seen)
        else $error("no target but target_in_view high");

    a_fnum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fnum != 2'd3)
        else $error("field number out of range");

    a_mag_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag <= MagMax)
        else $error("field magnitude above saturation");

    a_non_final_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && !is_final && !r_out_valid |=> !r_out_valid)
        else $error("result produced by a non-final character");

    a_held_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result_ch.ready |=> $stable(r_held_x) && $stable(r_held_y))
        else $error("held position changed while result stalled");
`endif

endmodule
